[rtl/dltq_pkg.sv]
// Package for the delta-list timer queue: field widths, codes, and the
// structs passed between the controller and the row of list cells.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package dltq_pkg;

  // Field widths of the input and result beats, and of the signed cell delta.
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TICK_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PEND_W  = 5;

  // Sizing of the queue and of one expiry burst.
  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS);

  // Command codes carried on the cmd field.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Signed relative delay held by each cell.
  typedef logic signed [DELTA_W-1:0] delta_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_INS_OK   = 2'd0,
    KIND_INS_FULL = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_WALK   = 3'd1,
    OP_ADJ    = 3'd2,
    OP_POP    = 3'd3,
    OP_INSERT = 3'd4
  } cell_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WALK   = 2'd1,
    ST_REJECT = 2'd2,
    ST_DRAIN  = 2'd3
  } ctl_state_e;

  // Command from the controller to the row of cells.
  typedef struct packed {
    cell_op_e            op;
    logic                start;
    delta_t              rem_in;
    delta_t              adj;
    logic [ID_W-1:0]     id;
  } cell_ctrl_t;

  // What one cell shows its neighbors: search token and stored entry.
  typedef struct packed {
    logic                tok;
    delta_t              rem;
    delta_t              delta;
    logic [ID_W-1:0]     id;
  } cell_data_t;

  // Status from the row back to the controller.
  typedef struct packed {
    logic                found;
    delta_t              head_delta;
    delta_t              next_delta;
    logic [ID_W-1:0]     head_id;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/dltq_if.sv]
// Valid/ready channel interfaces for the command and result beats.
// Depends on dltq_pkg for the field widths.
`default_nettype none

interface dltq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [dltq_pkg::DELAY_W-1:0] delay;
  logic [dltq_pkg::ID_W-1:0]    event_id;
  logic [dltq_pkg::TICK_W-1:0]  tick_count;

  modport source (output valid, cmd, delay, event_id, tick_count, input ready);
  modport sink   (input valid, cmd, delay, event_id, tick_count, output ready);
  modport mon    (input valid, ready, cmd, delay, event_id, tick_count);
endinterface

interface dltq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dltq_pkg::KIND_W-1:0]  kind;
  logic [dltq_pkg::ID_W-1:0]    expired_id;
  logic [dltq_pkg::PEND_W-1:0]  pending;
  logic                        last;

  modport source (output valid, kind, expired_id, pending, last, input ready);
  modport sink   (input valid, kind, expired_id, pending, last, output ready);
  modport mon    (input valid, ready, kind, expired_id, pending, last);
endinterface

`default_nettype wire

[rtl/dltq_cell.sv]
// One list cell: holds one entry (relative delay and id) plus the search
// token of an insert walk. Depends on dltq_pkg.
`default_nettype none

module dltq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dltq_pkg::cell_ctrl_t ctrl_i,
  input  dltq_pkg::delta_t     adj_i,
  input  dltq_pkg::cell_data_t left_i,
  input  dltq_pkg::cell_data_t right_i,
  output dltq_pkg::cell_data_t data_o,
  output logic                 pass_o
);

  logic                          tok_q, tok_d;
  logic                          passed_q, passed_d;
  dltq_pkg::delta_t              rem_q, rem_d;
  dltq_pkg::delta_t              delta_q, delta_d;
  logic [dltq_pkg::ID_W-1:0]     id_q, id_d;

  // Next state of the cell for the broadcast operation.
  always_comb begin
    tok_d    = tok_q;
    passed_d = passed_q;
    rem_d    = rem_q;
    delta_d  = delta_q;
    id_d     = id_q;
    unique case (ctrl_i.op)
      dltq_pkg::OP_HOLD: begin
      end
      dltq_pkg::OP_WALK: begin
        // The token moves one cell right, less the delta it stepped over.
        tok_d    = left_i.tok;
        rem_d    = left_i.rem - left_i.delta;
        passed_d = passed_q | tok_q;
      end
      dltq_pkg::OP_ADJ: begin
        delta_d = delta_q + adj_i;
      end
      dltq_pkg::OP_POP: begin
        // Shift left; the head cell also absorbs the overdue carry.
        delta_d = right_i.delta + adj_i;
        id_d    = right_i.id;
      end
      dltq_pkg::OP_INSERT: begin
        tok_d    = 1'b0;
        passed_d = 1'b0;
        if (!passed_q) begin
          priority if (tok_q) begin
            delta_d = rem_q;
            id_d    = ctrl_i.id;
          end else if (left_i.tok) begin
            // The follower of the new entry gives up the new remainder.
            delta_d = left_i.delta - left_i.rem;
            id_d    = left_i.id;
          end else begin
            delta_d = left_i.delta;
            id_d    = left_i.id;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control bits are reset; the entry itself is undefined until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      passed_q <= passed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    delta_q <= delta_d;
    id_q    <= id_d;
  end

  // The token may step past this entry when it fires no later than the new one.
  assign pass_o = (rem_q >= delta_q);

  assign data_o.tok   = tok_q;
  assign data_o.rem   = rem_q;
  assign data_o.delta = delta_q;
  assign data_o.id    = id_q;

endmodule

`default_nettype wire

[rtl/dltq_ctrl.sv]
// Controller of the timer queue: command decode, entry count, insert walk,
// expiry drain and the registered result beat. Depends on dltq_pkg, dltq_if.
`default_nettype none

module dltq_ctrl #(
  parameter int unsigned ENTRIES = dltq_pkg::ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dltq_in_if.sink              req_i,
  dltq_out_if.source           rsp_o,
  input  dltq_pkg::ctrl_stat_t stat_i,
  output dltq_pkg::cell_ctrl_t cell_ctrl_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  dltq_pkg::ctl_state_e              state_q, state_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [CNT_W-1:0]                  pos_q, pos_d;
  logic [dltq_pkg::NRES_W-1:0]       n_q, n_d;
  logic [dltq_pkg::ID_W-1:0]         id_q, id_d;

  logic                              out_valid_q, out_valid_d;
  dltq_pkg::kind_e                   kind_q, kind_d;
  logic [dltq_pkg::ID_W-1:0]         xid_q, xid_d;
  logic [dltq_pkg::PEND_W-1:0]       pend_q, pend_d;
  logic                              last_q, last_d;

  logic                              out_free;
  logic                              full;
  dltq_pkg::delta_t                  carry;
  dltq_pkg::delta_t                  next_head;
  logic                              expire;
  logic                              drain_last;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign full     = (count_q == CNT_W'(ENTRIES));

  // Overdue ticks of the head carry into the entry behind it.
  assign carry      = stat_i.head_delta[dltq_pkg::DELTA_W-1] ? stat_i.head_delta
                                                              : dltq_pkg::delta_t'(0);
  assign next_head  = stat_i.next_delta + carry;
  assign expire     = (count_q != '0) && (stat_i.head_delta <= dltq_pkg::delta_t'(0));
  assign drain_last = (count_q == CNT_W'(1)) || (next_head > dltq_pkg::delta_t'(0)) ||
                      (n_q == dltq_pkg::NRES_W'(dltq_pkg::MAX_RESULTS - 1));

  assign req_i.ready = (state_q == dltq_pkg::ST_IDLE);

  // Next state, cell command and result beat.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    n_d         = n_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    kind_d      = kind_q;
    xid_d       = xid_q;
    pend_d      = pend_q;
    last_d      = last_q;

    cell_ctrl_o.op     = dltq_pkg::OP_HOLD;
    cell_ctrl_o.start  = 1'b0;
    cell_ctrl_o.rem_in = dltq_pkg::delta_t'(req_i.delay);
    cell_ctrl_o.adj    = '0;
    cell_ctrl_o.id     = id_q;

    unique case (state_q)
      dltq_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          priority if (req_i.cmd == dltq_pkg::CMD_TICK) begin
            // Take the elapsed ticks off the head, then drain.
            cell_ctrl_o.op  = dltq_pkg::OP_ADJ;
            cell_ctrl_o.adj = -dltq_pkg::delta_t'(req_i.tick_count);
            n_d             = '0;
            state_d         = dltq_pkg::ST_DRAIN;
          end else if (full) begin
            state_d = dltq_pkg::ST_REJECT;
          end else begin
            // Launch the search token into the head cell.
            cell_ctrl_o.op    = dltq_pkg::OP_WALK;
            cell_ctrl_o.start = 1'b1;
            id_d              = req_i.event_id;
            pos_d             = '0;
            state_d           = dltq_pkg::ST_WALK;
          end
        end
      end
      dltq_pkg::ST_WALK: begin
        if ((pos_q == count_q) || stat_i.found) begin
          if (out_free) begin
            cell_ctrl_o.op = dltq_pkg::OP_INSERT;
            count_d        = count_q + CNT_W'(1);
            out_valid_d    = 1'b1;
            kind_d         = dltq_pkg::KIND_INS_OK;
            xid_d          = '0;
            pend_d         = dltq_pkg::PEND_W'(count_q + CNT_W'(1));
            last_d         = 1'b1;
            state_d        = dltq_pkg::ST_IDLE;
          end
        end else begin
          cell_ctrl_o.op = dltq_pkg::OP_WALK;
          pos_d          = pos_q + CNT_W'(1);
        end
      end
      dltq_pkg::ST_REJECT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = dltq_pkg::KIND_INS_FULL;
          xid_d       = '0;
          pend_d      = dltq_pkg::PEND_W'(count_q);
          last_d      = 1'b1;
          state_d     = dltq_pkg::ST_IDLE;
        end
      end
      dltq_pkg::ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (expire) begin
            // Pop the head and report it; one beat per cycle while the output is free.
            cell_ctrl_o.op  = dltq_pkg::OP_POP;
            cell_ctrl_o.adj = carry;
            count_d         = count_q - CNT_W'(1);
            n_d             = n_q + dltq_pkg::NRES_W'(1);
            kind_d          = dltq_pkg::KIND_EXPIRED;
            xid_d           = stat_i.head_id;
            pend_d          = dltq_pkg::PEND_W'(count_q - CNT_W'(1));
            last_d          = drain_last;
            if (drain_last) begin
              state_d = dltq_pkg::ST_IDLE;
            end
          end else begin
            kind_d  = dltq_pkg::KIND_NONE;
            xid_d   = '0;
            pend_d  = dltq_pkg::PEND_W'(count_q);
            last_d  = 1'b1;
            state_d = dltq_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dltq_pkg::ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    kind_q <= kind_d;
    xid_q  <= xid_d;
    pend_q <= pend_d;
    last_q <= last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = kind_q;
  assign rsp_o.expired_id = xid_q;
  assign rsp_o.pending    = pend_q;
  assign rsp_o.last       = last_q;

endmodule

`default_nettype wire

[rtl/delta_list_timer_queue_top.sv]
// Delta-list timer queue, top level: controller plus a row of ENTRIES cells.
// Depends on dltq_pkg, dltq_if, dltq_cell and dltq_ctrl.
//
// Usage:
//   req_i carries one command beat: cmd 0 inserts event_id to fire after
//   delay ticks, cmd 1 advances time by tick_count. rsp_o returns the result
//   beats of that command; the final one has last set.
//   An insert walks the list one cell per cycle and then registers its
//   single result. An insert into a full list goes through the reject state,
//   which registers the rejected result once the output register is free.
//   A tick adjusts the head in the cycle it is taken and then, while rsp_o
//   does not stall, pops one expired event per cycle, at most MAX_RESULTS
//   per tick; with nothing due it returns a single "nothing expired" beat.
//   One command is worked on at a time; req_i.ready returns high once the
//   last result beat sits in the output register, so the next command can
//   be taken while that beat still waits. A stall on rsp_o holds the drain,
//   or an insert at the end of its walk, where it is.
//   Reset empties the queue at once; there is no clearing pass.
`default_nettype none

module delta_list_timer_queue_top #(
  parameter int unsigned ENTRIES = dltq_pkg::ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dltq_in_if.sink    req_i,
  dltq_out_if.source rsp_o
);

  dltq_pkg::cell_ctrl_t  cell_ctrl;
  dltq_pkg::ctrl_stat_t  stat;
  dltq_pkg::cell_data_t  cell_data [ENTRIES];
  dltq_pkg::cell_data_t  head_feed;
  logic [ENTRIES-1:0]    pass;
  logic                  found;

  dltq_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .stat_i      (stat),
    .cell_ctrl_o (cell_ctrl)
  );

  // The head cell's left neighbor is the token launcher of the controller.
  assign head_feed.tok   = cell_ctrl.start;
  assign head_feed.rem   = cell_ctrl.rem_in;
  assign head_feed.delta = '0;
  assign head_feed.id    = cell_ctrl.id;

  // Row of cells, each wired to its two neighbors.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dltq_pkg::cell_data_t nb_left;
    dltq_pkg::cell_data_t nb_right;
    dltq_pkg::delta_t     adj;

    if (g == 0) begin : g_head
      assign nb_left = head_feed;
      assign adj     = cell_ctrl.adj;
    end else begin : g_body
      assign nb_left = cell_data[g-1];
      assign adj     = '0;
    end

    if (g == ENTRIES - 1) begin : g_tail
      assign nb_right = cell_data[g];
    end else begin : g_inner
      assign nb_right = cell_data[g+1];
    end

    dltq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .adj_i   (adj),
      .left_i  (nb_left),
      .right_i (nb_right),
      .data_o  (cell_data[g]),
      .pass_o  (pass[g])
    );
  end

  // The walk ends where the token meets an entry that fires later.
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      found = found | (cell_data[i].tok & ~pass[i]);
    end
  end

  assign stat.found      = found;
  assign stat.head_delta = cell_data[0].delta;
  assign stat.next_delta = cell_data[1].delta;
  assign stat.head_id    = cell_data[0].id;

endmodule

`default_nettype wire

[rtl/dltq_chk.sv]
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and dltq_if.
`default_nettype none

module dltq_chk (
  input logic         clk_i,
  input logic         rst_ni,
  dltq_in_if.sink     req_i,
  dltq_out_if.source  rsp_o
);

  // A command is worked on alone: no second beat is taken right behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("command taken while the previous one is still in work");

  // Only expiries come in bursts; every other result ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.kind != dltq_pkg::KIND_EXPIRED)) |-> rsp_o.last)
    else $error("non-expiry result without last");

  // The id field is cleared on every result that is not an expiry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.kind != dltq_pkg::KIND_EXPIRED)) |-> (rsp_o.expired_id == '0))
    else $error("stray expired_id on a non-expiry result");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=>
      (rsp_o.valid && $stable(rsp_o.kind) && $stable(rsp_o.expired_id) &&
       $stable(rsp_o.pending) && $stable(rsp_o.last)))
    else $error("result beat changed while stalled");

endmodule

bind delta_list_timer_queue_top dltq_chk u_dltq_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

`default_nettype wire

[dv/delta_list_timer_queue_top_tb.sv]
// Self-checking testbench for the delta-list timer queue top level.
// Depends on dltq_pkg, the dltq_in_if/dltq_out_if channels and the RTL top;
// a queue-fed driver and a clocked monitor check every result beat in order.
`default_nettype none

module delta_list_timer_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned CLK_HALF_NS = 6;
  localparam int unsigned STALL_PCT   = 30;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_CMDS = 410;

  // One command beat as the sender offers it.
  typedef struct packed {
    logic                         cmd;
    logic [dltq_pkg::DELAY_W-1:0] delay;
    logic [dltq_pkg::ID_W-1:0]    event_id;
    logic [dltq_pkg::TICK_W-1:0]  tick_count;
  } timer_cmd_t;

  // One result beat as the block should return it.
  typedef struct packed {
    dltq_pkg::kind_e             kind;
    logic [dltq_pkg::ID_W-1:0]   expired_id;
    logic [dltq_pkg::PEND_W-1:0] pending;
    logic                        last;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dltq_in_if  req_if ();
  dltq_out_if rsp_if ();

  delta_list_timer_queue_top #(
    .ENTRIES (SLOTS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Commands still to be offered, and result beats still owed by the block.
  timer_cmd_t cmd_fifo[$];
  timer_rsp_t owed_rsps[$];
  timer_cmd_t drive_cmd;

  // Shadow of the queue contents: relative delays, identifiers and fill level.
  dltq_pkg::delta_t          shadow_delta [SLOTS];
  logic [dltq_pkg::ID_W-1:0] shadow_id    [SLOTS];
  int unsigned               shadow_count;

  int unsigned accepted_cmds;
  int unsigned n_inserts, n_ticks;
  int unsigned n_ok, n_full, n_expired, n_quiet;
  int unsigned err_count;
  logic        hold_rsp;
  logic        no_idle;

  // Clock generation.
  always begin
    #(CLK_HALF_NS) clk_i = 1'b1;
    #(CLK_HALF_NS) clk_i = 1'b0;
  end

  // Known levels on every input before the first clock edge.
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.cmd        = dltq_pkg::CMD_INSERT;
    req_if.delay      = '0;
    req_if.event_id   = '0;
    req_if.tick_count = '0;
    rsp_if.ready      = 1'b0;
    hold_rsp          = 1'b0;
    no_idle           = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Work out the result beats of one accepted command and queue them.
  task automatic predict_timer_results(timer_cmd_t c);
    int unsigned pos;
    int          rem;
    int          carry;
    int          t;
    int          n;
    logic [dltq_pkg::ID_W-1:0] eid;
    timer_rsp_t  r;
    if (c.cmd == dltq_pkg::CMD_INSERT) begin
      n_inserts++;
      if (shadow_count >= SLOTS) begin
        r = '{dltq_pkg::KIND_INS_FULL, '0, dltq_pkg::PEND_W'(shadow_count), 1'b1};
        owed_rsps.push_back(r);
      end else begin
        // Walk past every entry that fires at or before the new one.
        pos = 0;
        rem = int'(c.delay);
        while (pos < shadow_count && rem >= int'(shadow_delta[pos])) begin
          rem -= int'(shadow_delta[pos]);
          pos++;
        end
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_delta[i] = shadow_delta[i-1];
          shadow_id[i]    = shadow_id[i-1];
        end
        shadow_delta[pos] = dltq_pkg::delta_t'(rem);
        shadow_id[pos]    = c.event_id;
        shadow_count++;
        if (pos + 1 < shadow_count) begin
          shadow_delta[pos+1] = dltq_pkg::delta_t'(int'(shadow_delta[pos+1]) - rem);
        end
        r = '{dltq_pkg::KIND_INS_OK, '0, dltq_pkg::PEND_W'(shadow_count), 1'b1};
        owed_rsps.push_back(r);
      end
    end else begin
      n_ticks++;
      n = 0;
      if (shadow_count > 0) begin
        carry = int'(c.tick_count) - int'(shadow_delta[0]);
        shadow_delta[0] = dltq_pkg::delta_t'(int'(shadow_delta[0]) - int'(c.tick_count));
        // Pop every due head; leftover ticks carry into the next entry.
        while (shadow_count > 0 && shadow_delta[0] <= 0 && n < dltq_pkg::MAX_RESULTS) begin
          eid = shadow_id[0];
          for (int unsigned i = 0; i + 1 < shadow_count; i++) begin
            shadow_delta[i] = shadow_delta[i+1];
            shadow_id[i]    = shadow_id[i+1];
          end
          shadow_count--;
          if (carry > 0 && shadow_count > 0) begin
            t = carry - int'(shadow_delta[0]);
            shadow_delta[0] = dltq_pkg::delta_t'(int'(shadow_delta[0]) - carry);
            carry = t;
          end
          r = '{dltq_pkg::KIND_EXPIRED, eid, dltq_pkg::PEND_W'(shadow_count), 1'b0};
          owed_rsps.push_back(r);
          n++;
        end
      end
      if (n == 0) begin
        r = '{dltq_pkg::KIND_NONE, '0, dltq_pkg::PEND_W'(shadow_count), 1'b1};
        owed_rsps.push_back(r);
      end else begin
        owed_rsps[owed_rsps.size()-1].last = 1'b1;
      end
    end
  endtask

  // Compare one returned beat with the oldest owed result.
  task automatic check_timer_result();
    timer_rsp_t want;
    if (owed_rsps.size() == 0) begin
      report_mismatch("unexpected beat kind", int'(rsp_if.kind), -1);
    end else begin
      want = owed_rsps.pop_front();
      if (rsp_if.kind != want.kind)
        report_mismatch("kind", int'(rsp_if.kind), int'(want.kind));
      if (rsp_if.expired_id != want.expired_id)
        report_mismatch("expired_id", int'(rsp_if.expired_id), int'(want.expired_id));
      if (rsp_if.pending != want.pending)
        report_mismatch("pending", int'(rsp_if.pending), int'(want.pending));
      if (rsp_if.last != want.last)
        report_mismatch("last", int'(rsp_if.last), int'(want.last));
      case (want.kind)
        dltq_pkg::KIND_INS_OK:   n_ok++;
        dltq_pkg::KIND_INS_FULL: n_full++;
        dltq_pkg::KIND_EXPIRED:  n_expired++;
        default:                 n_quiet++;
      endcase
    end
  endtask

  // Command driver: holds a beat until it is taken, otherwise offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid  <= 1'b0;
      accepted_cmds <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_timer_results(drive_cmd);
        accepted_cmds <= accepted_cmds + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_fifo.size() != 0 && (no_idle || $urandom_range(0, 99) >= STALL_PCT)) begin
          drive_cmd = cmd_fifo.pop_front();
          req_if.valid      <= 1'b1;
          req_if.cmd        <= drive_cmd.cmd;
          req_if.delay      <= drive_cmd.delay;
          req_if.event_id   <= drive_cmd.event_id;
          req_if.tick_count <= drive_cmd.tick_count;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_timer_result();
      end
      rsp_if.ready <= !hold_rsp && (no_idle || $urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Long receiver hold-off so the block fills and stalls its input, then a
  // long window with no idling on either side.
  initial begin
    @(posedge rst_ni);
    while (accepted_cmds < 100) @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
    while (accepted_cmds < 250) @(posedge clk_i);
    no_idle <= 1'b1;
    repeat (800) @(posedge clk_i);
    no_idle <= 1'b0;
  end

  function automatic void push_insert(int unsigned dly, int unsigned id);
    timer_cmd_t c;
    c.cmd        = dltq_pkg::CMD_INSERT;
    c.delay      = dltq_pkg::DELAY_W'(dly);
    c.event_id   = dltq_pkg::ID_W'(id);
    c.tick_count = dltq_pkg::TICK_W'($urandom);
    cmd_fifo.push_back(c);
  endfunction

  function automatic void push_tick(int unsigned cnt);
    timer_cmd_t c;
    c.cmd        = dltq_pkg::CMD_TICK;
    c.delay      = dltq_pkg::DELAY_W'($urandom);
    c.event_id   = dltq_pkg::ID_W'($urandom);
    c.tick_count = dltq_pkg::TICK_W'(cnt);
    cmd_fifo.push_back(c);
  endfunction

  // Mostly short delays so events fire within the run; many ties, a few long.
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 1)  return $urandom_range(0, 65535);
    if (r < 20) return $urandom_range(0, 3000);
    if (r < 40) return $urandom_range(0, 8);
    return $urandom_range(0, 400);
  endfunction

  // Stimulus: directed corners, a full drain, then random traffic.
  initial begin
    int unsigned made;
    int unsigned r;
    shadow_count = 0;
    n_inserts = 0; n_ticks = 0;
    n_ok = 0; n_full = 0; n_expired = 0; n_quiet = 0;
    err_count = 0;

    // Ticks on an empty list, smallest and largest count.
    push_tick(0);
    push_tick(255);
    // Fill the list: ties at zero and five, extreme delay and identifiers.
    push_insert(0, 8'h00);
    push_insert(0, 8'hFF);
    push_insert(5, 1);
    push_insert(5, 2);
    push_insert(3, 3);
    push_insert(65535, 4);
    push_insert(1, 5);
    push_insert(200, 6);
    push_insert(100, 7);
    push_insert(100, 8);
    push_insert(40, 9);
    push_insert(250, 10);
    push_insert(7, 11);
    push_insert(5, 12);
    push_insert(180, 13);
    push_insert(60, 14);
    // Insert into a full list is rejected.
    push_insert(10, 99);
    // A zero tick still expires heads already at zero.
    push_tick(0);
    // Leftover ticks carry across several expirations.
    push_tick(3);
    push_tick(255);
    // Tick that only shortens the head.
    push_tick(1);

    // Sender pause until every owed result has come back.
    @(posedge rst_ni);
    while (cmd_fifo.size() != 0 || req_if.valid) @(posedge clk_i);
    while (owed_rsps.size() != 0) @(posedge clk_i);

    // Random traffic with occasional fill bursts that hit the full case.
    made = 0;
    while (made < RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat (18) push_insert($urandom_range(0, 300), $urandom_range(0, 255));
        repeat (4) push_tick($urandom_range(150, 255));
        made += 22;
      end else if (r < 58) begin
        push_insert(pick_delay(), $urandom_range(0, 255));
        made++;
      end else begin
        push_tick($urandom_range(0, 255));
        made++;
      end
    end

    while (cmd_fifo.size() != 0 || req_if.valid) @(posedge clk_i);
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);
    while (owed_rsps.size() != 0) begin
      report_mismatch("result never returned, kind", -1, int'(owed_rsps[0].kind));
      void'(owed_rsps.pop_front());
    end

    $display("Ran %0d inserts and %0d ticks: %0d placed, %0d refused on a full list,",
             n_inserts, n_ticks, n_ok, n_full);
    $display("%0d events fired, %0d ticks with nothing due, %0d mismatches.",
             n_expired, n_quiet, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
